/* src/fts_pkg.sv */
// ----------------------------------------------------------------------------
// fts_pkg
// Shared types and constants of the fan tachometer stall monitor.
// ----------------------------------------------------------------------------
`default_nettype none

package fts_pkg;

  localparam int unsigned CountW = 16;
  localparam int unsigned FailW  = 2;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CountW-1:0] EdgeStop        = 16'hFFF1;
  localparam logic [CountW-1:0] WindowTicksRst  = 16'd50000;
  localparam logic [CountW-1:0] MinEdgesRst     = 16'd125;
  localparam logic [FailW-1:0]  FailLimitRst    = 2'd3;

  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_CHECK  = 1'b1
  } fts_cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_WINDOW_TICKS = 2'd0,
    REG_MIN_EDGES    = 2'd1,
    REG_FAIL_LIMIT   = 2'd2,
    REG_UNUSED       = 2'd3
  } fts_reg_e;

  typedef struct packed {
    logic [CountW-1:0] window_ticks;
    logic [CountW-1:0] min_edges;
    logic [FailW-1:0]  fail_limit;
  } fts_cfg_t;

  typedef struct packed {
    logic              sample;
    logic              check;
    logic              level;
    logic              fan_on;
  } fts_chan_ctl_t;

  typedef struct packed {
    logic              error;
    logic [CountW-1:0] pulses;
  } fts_chan_stat_t;

endpackage

`default_nettype wire

/* src/fts_item_if.sv */
// ----------------------------------------------------------------------------
// fts_item_if
// Input channel: sample and check transactions with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface fts_item_if;
  logic valid;
  logic ready;
  logic cmd;
  logic in_feedback;
  logic out_feedback;
  logic in_fan_on;
  logic out_fan_on;
  logic test_mode;

  modport source (
    output valid, cmd, in_feedback, out_feedback, in_fan_on, out_fan_on, test_mode,
    input  ready
  );
  modport sink (
    input  valid, cmd, in_feedback, out_feedback, in_fan_on, out_fan_on, test_mode,
    output ready
  );
endinterface

`default_nettype wire

/* src/fts_result_if.sv */
// ----------------------------------------------------------------------------
// fts_result_if
// Result channel: error flags and pulse counts with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface fts_result_if;
  logic        valid;
  logic        ready;
  logic        in_error;
  logic        out_error;
  logic [15:0] in_pulses;
  logic [15:0] out_pulses;

  modport source (
    output valid, in_error, out_error, in_pulses, out_pulses,
    input  ready
  );
  modport sink (
    input  valid, in_error, out_error, in_pulses, out_pulses,
    output ready
  );
endinterface

`default_nettype wire

/* src/fts_chan.sv */
// ----------------------------------------------------------------------------
// fts_chan
// One tachometer channel: edge counter, window timer, fail counter, error.
// ----------------------------------------------------------------------------
`default_nettype none

module fts_chan
  import fts_pkg::*;
(
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire fts_cfg_t       cfg_i,
  input  wire fts_chan_ctl_t  ctl_i,
  output fts_chan_stat_t      stat_o
);

  logic              prev_q, prev_d;
  logic [CountW-1:0] edges_q, edges_d;
  logic [CountW-1:0] timer_q, timer_d;
  logic [FailW-1:0]  fail_q, fail_d;
  logic              err_q, err_d;

  logic [CountW:0]   timer_inc;
  logic [FailW:0]    fail_inc;

  always_comb begin
    prev_d    = prev_q;
    edges_d   = edges_q;
    timer_d   = timer_q;
    fail_d    = fail_q;
    err_d     = err_q;
    timer_inc = {1'b0, timer_q} + {{CountW{1'b0}}, 1'b1};
    fail_inc  = {1'b0, fail_q} + {{FailW{1'b0}}, 1'b1};

    if (ctl_i.sample) begin
      if (ctl_i.level && !prev_q && (edges_q < EdgeStop)) begin
        edges_d = edges_q + CountW'(1);
      end
      prev_d = ctl_i.level;
    end else if (ctl_i.check) begin
      if (!ctl_i.fan_on) begin
        edges_d = '0;
        timer_d = '0;
        fail_d  = '0;
      end else if (timer_inc < {1'b0, cfg_i.window_ticks}) begin
        timer_d = timer_inc[CountW-1:0];
      end else begin
        timer_d = '0;
        edges_d = '0;
        if (edges_q < cfg_i.min_edges) begin
          if (fail_inc >= {1'b0, cfg_i.fail_limit}) begin
            fail_d = cfg_i.fail_limit;
            err_d  = 1'b1;
          end else begin
            fail_d = fail_inc[FailW-1:0];
          end
        end else begin
          fail_d = '0;
          err_d  = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= 1'b0;
      edges_q <= '0;
      timer_q <= '0;
      fail_q  <= '0;
      err_q   <= 1'b0;
    end else begin
      prev_q  <= prev_d;
      edges_q <= edges_d;
      timer_q <= timer_d;
      fail_q  <= fail_d;
      err_q   <= err_d;
    end
  end

  assign stat_o.error  = err_d;
  assign stat_o.pulses = edges_d;

endmodule

`default_nettype wire

/* src/fan_tach_stall_monitor.sv */
// ----------------------------------------------------------------------------
// fan_tach_stall_monitor
// Two-channel fan tachometer monitor with window-based stall detection.
// ----------------------------------------------------------------------------
// Usage:
//   item_i   : sample transactions (cmd 0) carry both tach levels; check
//              transactions (cmd 1) carry the fan on flags and test mode.
//   result_o : one transaction per input transaction with both error flags
//              and both pulse counts as they stand after the update.
//   cfg_*    : register writes (window ticks, min edges, fail limit); the
//              user has them taken only while no transaction is in flight.
// The block does not enforce this. Channel state and the result register load
// at the same edge that accepts the input transaction. One transaction per
// cycle is sustained while the receiver is ready; the single output register
// is the only buffer. When the receiver stalls, the result register holds and
// item_i.ready drops until the result is taken. Reset clears all channel state
// and the output valid and loads the register defaults (50000, 125, 3).
// ----------------------------------------------------------------------------
`default_nettype none

module fan_tach_stall_monitor
  import fts_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  fts_item_if.sink                 item_i,
  fts_result_if.source             result_o
);

  fts_cfg_t       cfg_q;
  fts_chan_ctl_t  in_ctl, out_ctl;
  fts_chan_stat_t in_stat, out_stat;
  logic           accept;
  logic           check_run;
  logic           valid_q;
  logic           in_err_q, out_err_q;
  logic [CountW-1:0] in_pulses_q, out_pulses_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_ticks <= WindowTicksRst;
      cfg_q.min_edges    <= MinEdgesRst;
      cfg_q.fail_limit   <= FailLimitRst;
    end else if (cfg_we_i) begin
      unique case (fts_reg_e'(cfg_idx_i))
        REG_WINDOW_TICKS: cfg_q.window_ticks <= cfg_wdata_i;
        REG_MIN_EDGES:    cfg_q.min_edges    <= cfg_wdata_i;
        REG_FAIL_LIMIT:   cfg_q.fail_limit   <= cfg_wdata_i[FailW-1:0];
        REG_UNUSED:       ;
        default:          ;
      endcase
    end
  end

  assign item_i.ready = !valid_q || result_o.ready;
  assign accept       = item_i.valid && item_i.ready;
  assign check_run    = accept && (fts_cmd_e'(item_i.cmd) == CMD_CHECK) && !item_i.test_mode;

  assign in_ctl.sample  = accept && (fts_cmd_e'(item_i.cmd) == CMD_SAMPLE);
  assign in_ctl.check   = check_run;
  assign in_ctl.level   = item_i.in_feedback;
  assign in_ctl.fan_on  = item_i.in_fan_on;
  assign out_ctl.sample = in_ctl.sample;
  assign out_ctl.check  = check_run;
  assign out_ctl.level  = item_i.out_feedback;
  assign out_ctl.fan_on = item_i.out_fan_on;

  fts_chan u_in_chan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .ctl_i  (in_ctl),
    .stat_o (in_stat)
  );

  fts_chan u_out_chan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .ctl_i  (out_ctl),
    .stat_o (out_stat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (item_i.ready) begin
      valid_q <= item_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_err_q     <= in_stat.error;
      out_err_q    <= out_stat.error;
      in_pulses_q  <= in_stat.pulses;
      out_pulses_q <= out_stat.pulses;
    end
  end

  assign result_o.valid      = valid_q;
  assign result_o.in_error   = in_err_q;
  assign result_o.out_error  = out_err_q;
  assign result_o.in_pulses  = in_pulses_q;
  assign result_o.out_pulses = out_pulses_q;

endmodule

`default_nettype wire
